// ===== rtl/smop_pkg.sv =====
// Shared constants for the square matrix operation engine.
// Depends on nothing; the top level refers to it by scoped names.
package smop_pkg;

	// Field widths of the stream items.
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned ELEM_W  = 16;
	localparam int unsigned ACC_W   = 36;
	localparam int unsigned PROD_W  = 2 * ELEM_W;
	localparam int unsigned SIZE_W  = 5;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 40;

	// Item kinds carried in s_tuser.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Operation codes held in the mode register.
	localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PROD = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_MODE = 1'b1;

	// Register reset values.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

endpackage

// ===== rtl/smop_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module smop_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/square_matrix_op_engine.sv =====
// Square matrix operation engine: two element stores, one shared multiply-add unit.
// Depends on smop_pkg and smop_ram.
//
// A load beat writes one element of each matrix in the cycle it is accepted, so loads
// stream one per cycle while no query is in work. A sum or difference query passes a read
// step and an add step before the finish step puts the result in the output register;
// a product query runs the multiply-accumulate loop over the active size, reading one
// row element and one column element per cycle through the single read port of each
// store, then drains its pipeline. Queries with a bad index or the unused mode go
// straight to the finish step. The input is not ready while a query is worked on; a
// finished result waits in the output register while new beats are accepted. The
// stores are not cleared: an element must be loaded before a query uses it.
module square_matrix_op_engine #(
	parameter int unsigned MAX_DIM = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // row[3:0], col[7:4], a_value[23:8], b_value[39:24]
	input  logic        s_tuser,   // kind
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value[35:0], zero fill[39:36]
	output logic        m_tuser,   // bad_index
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [smop_pkg::SIZE_W-1:0] MAX_N =
		(MAX_DIM > 31) ? 5'd31 : smop_pkg::SIZE_W'(MAX_DIM);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EW_RD,
		ST_EW_ADD,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [smop_pkg::SIZE_W-1:0] size_q;
	logic [smop_pkg::MODE_W-1:0] mode_q;

	// Input field unpacking.
	logic [smop_pkg::IDX_W-1:0]  in_row;
	logic [smop_pkg::IDX_W-1:0]  in_col;
	logic [smop_pkg::ELEM_W-1:0] in_a;
	logic [smop_pkg::ELEM_W-1:0] in_b;

	assign in_row = s_tdata[3:0];
	assign in_col = s_tdata[7:4];
	assign in_a   = s_tdata[23:8];
	assign in_b   = s_tdata[39:24];

	logic [smop_pkg::IDX_W-1:0]  row_q;
	logic [smop_pkg::IDX_W-1:0]  col_q;
	logic                        ok_q;
	logic [smop_pkg::SIZE_W-1:0] k_q;
	logic [smop_pkg::ACC_W-1:0]  acc_q;
	logic                        rd_vld_s1;
	logic                        mul_vld_s2;
	logic [smop_pkg::PROD_W-1:0] prod_s2;
	logic                        m_tvalid_q;
	logic [smop_pkg::ACC_W-1:0]  value_q;
	logic                        bad_q;

	// Configuration registers; writes land on the access phase.
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= smop_pkg::SIZE_RESET;
			mode_q <= smop_pkg::MODE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == smop_pkg::REG_SIZE) begin
				size_q <= pwdata[smop_pkg::SIZE_W-1:0];
			end else begin
				mode_q <= pwdata[smop_pkg::MODE_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == smop_pkg::REG_SIZE) begin
			prdata = {27'b0, size_q};
		end else begin
			prdata = {30'b0, mode_q};
		end
	end

	// Active size and index check of the incoming beat.
	logic [smop_pkg::SIZE_W-1:0] n_act;
	logic                        in_ok;
	logic                        s_acc;

	assign n_act = (size_q > MAX_N) ? MAX_N : size_q;
	assign in_ok = ({1'b0, in_row} < n_act) && ({1'b0, in_col} < n_act);
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid & s_tready;

	// Element stores: loads write both at the same cell.
	logic              ram_we;
	logic [AW-1:0]     wr_addr;
	logic              ram_re;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	logic [smop_pkg::ELEM_W-1:0] a_rd;
	logic [smop_pkg::ELEM_W-1:0] b_rd;

	assign ram_we  = s_acc && (s_tuser == smop_pkg::KIND_LOAD) && in_ok;
	assign wr_addr = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));

	always_comb begin
		ram_re = 1'b0;
		rd_addr_a = AW'(AW'(row_q) * AW'(MAX_DIM) + AW'(col_q));
		rd_addr_b = rd_addr_a;
		case (state_q)
			ST_EW_RD: begin
				ram_re = 1'b1;
			end
			ST_MAC: begin
				ram_re = 1'b1;
				rd_addr_a = AW'(AW'(row_q) * AW'(MAX_DIM) + AW'(k_q));
				rd_addr_b = AW'(AW'(k_q) * AW'(MAX_DIM) + AW'(col_q));
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	smop_ram #(
		.WIDTH(smop_pkg::ELEM_W),
		.DEPTH(CELLS)
	) u_first_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(in_a),
		.re   (ram_re),
		.raddr(rd_addr_a),
		.rdata(a_rd)
	);

	smop_ram #(
		.WIDTH(smop_pkg::ELEM_W),
		.DEPTH(CELLS)
	) u_second_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(in_b),
		.re   (ram_re),
		.raddr(rd_addr_b),
		.rdata(b_rd)
	);

	// Shared adder: element-wise sum or difference, or accumulation of a product.
	logic [smop_pkg::ACC_W-1:0] a_ext;
	logic [smop_pkg::ACC_W-1:0] b_ext;
	logic [smop_pkg::ACC_W-1:0] op_x;
	logic [smop_pkg::ACC_W-1:0] op_y;
	logic [smop_pkg::ACC_W-1:0] add_out;

	assign a_ext = {{(smop_pkg::ACC_W - smop_pkg::ELEM_W){a_rd[smop_pkg::ELEM_W-1]}}, a_rd};
	assign b_ext = {{(smop_pkg::ACC_W - smop_pkg::ELEM_W){b_rd[smop_pkg::ELEM_W-1]}}, b_rd};

	always_comb begin
		if (state_q == ST_EW_ADD) begin
			op_x = a_ext;
			op_y = (mode_q == smop_pkg::MODE_DIFF) ? (~b_ext + 1'b1) : b_ext;
		end else begin
			op_x = acc_q;
			op_y = {{(smop_pkg::ACC_W - smop_pkg::PROD_W){prod_s2[smop_pkg::PROD_W-1]}},
				prod_s2};
		end
	end

	assign add_out = op_x + op_y;

	// Sequencer with its control pipeline and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_MAC);
			mul_vld_s2 <= rd_vld_s1;
			// The output beat is reloaded from the finish step or retired on a handshake.
			if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == smop_pkg::KIND_QUERY)) begin
						if (!in_ok) begin
							state_q <= ST_FINISH;
						end else begin
							case (mode_q)
								smop_pkg::MODE_SUM,
								smop_pkg::MODE_DIFF: state_q <= ST_EW_RD;
								smop_pkg::MODE_PROD: state_q <= ST_MAC;
								default:             state_q <= ST_FINISH;
							endcase
						end
					end
				end
				ST_EW_RD: begin
					state_q <= ST_EW_ADD;
				end
				ST_EW_ADD: begin
					state_q <= ST_FINISH;
				end
				ST_MAC: begin
					if (k_q == n_act - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !mul_vld_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the query in work and the output beat.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_q <= in_row;
			col_q <= in_col;
			ok_q  <= in_ok;
			k_q   <= '0;
			acc_q <= '0;
		end else begin
			if (state_q == ST_MAC) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == ST_EW_ADD || mul_vld_s2) begin
				acc_q <= add_out;
			end
		end
		if (rd_vld_s1) begin
			prod_s2 <= smop_pkg::PROD_W'($signed(a_rd) * $signed(b_rd));
		end
		if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
			value_q <= acc_q;
			bad_q   <= !ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, value_q};
	assign m_tuser  = bad_q;

`ifndef SYNTHESIS
	// A bad index always comes with a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[35:0] == 36'd0)
		else $error("bad index result carries a nonzero value");

	// Stores are written only while no query is in work.
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("store written during a query");

	// A new result appears only out of the finish step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_FINISH)
		else $error("result raised outside the finish step");

	// A product enters the accumulator only after its operands were read.
	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		mul_vld_s2 |-> $past(rd_vld_s1))
		else $error("product without a preceding read");
`endif

endmodule
